// ===== rtl/core/mfq_pkg.sv =====
// Shared types and constants for the multilevel feedback queue scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package mfq_pkg;

    // field widths
    localparam int unsigned CMD_W     = 1;
    localparam int unsigned SLOT_W    = 3;
    localparam int unsigned DATA_W    = 16;
    localparam int unsigned LEVEL_W   = 2;
    localparam int unsigned ELAPSED_W = 32;
    localparam int unsigned LEVELS    = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SCHED = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0_QUANTUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_QUANTUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2_QUANTUM = 2'd2;

    // quantum reset values
    localparam logic [DATA_W-1:0] QUANTUM0_RESET = 16'd10;
    localparam logic [DATA_W-1:0] QUANTUM1_RESET = 16'd20;
    localparam logic [DATA_W-1:0] QUANTUM2_RESET = 16'd40;

    // queue levels
    localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LAST = 2'd2;

    // a schedule command gives up after this many passes
    localparam int unsigned PASS_W = 3;
    localparam logic [PASS_W-1:0] MAX_PASSES = 3'd6;

    // command queue between front and back
    localparam int unsigned CMDQ_DEPTH = 2;
    localparam int unsigned CMDQ_PTR_W = 1;
    localparam int unsigned CMDQ_CNT_W = 2;

    typedef logic [LEVELS-1:0][DATA_W-1:0] quanta_t;

    // classified command as it travels from front to back
    typedef struct packed {
        logic              sched;
        logic              load_ok;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] burst;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [SLOT_W-1:0]    job_slot;
        logic [DATA_W-1:0]    run_units;
        logic [DATA_W-1:0]    time_left;
        logic [LEVEL_W-1:0]   job_level;
        logic                 finished;
        logic [ELAPSED_W-1:0] elapsed;
        logic                 all_done;
    } res_t;

    // back end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/mfq_front.sv =====
// Front end: takes input transfers, classifies them and holds them in a short queue.
// Depends on mfq_pkg.
`default_nettype none

module mfq_front
    import mfq_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [DATA_W-1:0] burst,
    output logic                   cmd_valid,
    output cmd_t                   cmd,
    input  wire logic              cmd_pop
);

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg;
    logic [CMDQ_CNT_W-1:0] cnt_next;
    cmd_t                  cls;
    logic                  do_push;
    logic                  do_pop;

    // classify the incoming item
    always_comb
    begin
        cls.sched   = (command == CMD_SCHED);
        cls.load_ok = (command == CMD_LOAD) && (int'(slot) < int'(NUM_SLOTS));
        cls.slot    = slot;
        cls.burst   = burst;
    end

    assign full      = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mfq_back.sv =====
// Back end: slot store, scan sequencer, dispatch arithmetic and result register.
// Depends on mfq_pkg.
`default_nettype none

module mfq_back
    import mfq_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 8
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cmd_valid,
    input  wire cmd_t    cmd,
    output logic         cmd_pop,
    input  wire quanta_t quanta,
    output logic         empty,
    output res_t         res,
    input  wire logic    pop
);

    localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned PW = $clog2(NUM_SLOTS + 1);

    // slot remaining time, no reset: an inactive slot is never read for use
    logic [DATA_W-1:0] rem_mem [NUM_SLOTS];
    logic [DATA_W-1:0] rem_rd_reg;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              rd_en;

    back_state_t                 state_reg, state_next;
    logic [NUM_SLOTS-1:0]        nz_reg, nz_next;
    logic [LEVELS-1:0][NUM_SLOTS-1:0] lvl_reg, lvl_next;
    logic [PW-1:0]               act_reg, act_next;
    logic [LEVEL_W-1:0]          cur_reg, cur_next;
    logic [PW-1:0]               pos_reg, pos_next;
    logic                        pf_reg, pf_next;
    logic [PASS_W-1:0]           pass_reg, pass_next;
    logic [IW-1:0]               hit_reg, hit_next;
    logic [ELAPSED_W-1:0]        elapsed_reg, elapsed_next;
    logic                        out_valid_reg, out_valid_next;
    res_t                        res_reg, res_next;

    logic [IW-1:0]      scan_idx;
    logic               in_range;
    logic               hit;
    logic [IW-1:0]      load_idx;
    logic               load_nz;
    logic [PASS_W-1:0]  pass_inc;
    logic [LEVEL_W-1:0] lvl_adv;
    logic [DATA_W-1:0]  q;
    logic [DATA_W-1:0]  run;
    logic [DATA_W-1:0]  left;
    logic               out_free;

    // scan position decode
    assign scan_idx = pos_reg[IW-1:0];
    assign in_range = (pos_reg < PW'(NUM_SLOTS));
    assign hit      = in_range && nz_reg[scan_idx] && lvl_reg[cur_reg][scan_idx];
    assign rd_en    = (state_reg == ST_SCAN) && in_range;

    assign load_idx = IW'(cmd.slot);
    assign load_nz  = (cmd.burst != '0);
    assign pass_inc = pass_reg + 1'b1;
    assign lvl_adv  = (cur_reg == LEVEL_LAST) ? LEVEL_TOP : cur_reg + 1'b1;

    // dispatch arithmetic
    assign q        = quanta[cur_reg];
    assign run      = (rem_rd_reg <= q) ? rem_rd_reg : q;
    assign left     = rem_rd_reg - run;
    assign out_free = !out_valid_reg || pop;

    assign empty = !out_valid_reg;
    assign res   = res_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        nz_next        = nz_reg;
        lvl_next       = lvl_reg;
        act_next       = act_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        pf_next        = pf_reg;
        pass_next      = pass_reg;
        hit_next       = hit_reg;
        elapsed_next   = elapsed_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = load_idx;
        mem_wdata      = cmd.burst;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.sched)
                    begin
                        pass_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else if (cmd.load_ok)
                    begin
                        // load a slot and place it at the top level
                        mem_we = 1'b1;
                        nz_next[load_idx] = load_nz;
                        for (int l = 0; l < LEVELS; l++)
                        begin
                            lvl_next[l][load_idx] = (l == 0);
                        end
                        if (load_nz && !nz_reg[load_idx])
                        begin
                            act_next = act_reg + 1'b1;
                        end
                        else if (!load_nz && nz_reg[load_idx])
                        begin
                            act_next = act_reg - 1'b1;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (in_range)
                begin
                    pos_next = pos_reg + 1'b1;
                    if (hit)
                    begin
                        hit_next   = scan_idx;
                        state_next = ST_EXEC;
                    end
                end
                else
                begin
                    // end of a pass
                    pos_next  = '0;
                    pass_next = pass_inc;
                    if (pf_reg)
                    begin
                        pf_next = 1'b0;
                    end
                    else
                    begin
                        cur_next = lvl_adv;
                    end
                    if ((!pf_reg && lvl_adv == LEVEL_TOP && act_reg == '0)
                        || pass_inc == MAX_PASSES)
                    begin
                        cur_next   = LEVEL_TOP;
                        pf_next    = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = hit_reg;
                    mem_wdata    = left;
                    pf_next      = 1'b1;
                    elapsed_next = elapsed_reg + ELAPSED_W'(run);
                    if (left == '0)
                    begin
                        nz_next[hit_reg] = 1'b0;
                        act_next         = act_reg - 1'b1;
                    end
                    else if (cur_reg != LEVEL_LAST)
                    begin
                        lvl_next[cur_reg][hit_reg]        = 1'b0;
                        lvl_next[lvl_adv][hit_reg]        = 1'b1;
                    end
                    res_next.job_slot  = SLOT_W'(hit_reg);
                    res_next.run_units = run;
                    res_next.time_left = left;
                    res_next.job_level = cur_reg;
                    res_next.finished  = (left == '0);
                    res_next.elapsed   = elapsed_reg + ELAPSED_W'(run);
                    res_next.all_done  = 1'b0;
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    res_next.job_slot  = '0;
                    res_next.run_units = '0;
                    res_next.time_left = '0;
                    res_next.job_level = '0;
                    res_next.finished  = 1'b0;
                    res_next.elapsed   = elapsed_reg;
                    res_next.all_done  = 1'b1;
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nz_reg        <= '0;
            // every slot starts at the top level
            lvl_reg       <= {{((LEVELS-1)*NUM_SLOTS){1'b0}}, {NUM_SLOTS{1'b1}}};
            act_reg       <= '0;
            cur_reg       <= LEVEL_TOP;
            pos_reg       <= '0;
            pf_reg        <= 1'b0;
            pass_reg      <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nz_reg        <= nz_next;
            lvl_reg       <= lvl_next;
            act_reg       <= act_next;
            cur_reg       <= cur_next;
            pos_reg       <= pos_next;
            pf_reg        <= pf_next;
            pass_reg      <= pass_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        res_reg <= res_next;
    end

    // remaining time memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rem_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rem_rd_reg <= rem_mem[scan_idx];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/multilevel_feedback_queue_scheduler.sv =====
// Three-level feedback queue scheduler over NUM_SLOTS job slots. A load
// command is taken by the back end and gives no result. A schedule
// command scans the slots in passes over the levels; the scan sequencer
// checks one slot a cycle against the level bits, then reads the slot's
// remaining time from the memory and dispatches. A two-entry command queue
// lets input transfers continue while the back end scans, and a result
// register holds the oldest result until it is popped.
// Depends on mfq_pkg, mfq_front and mfq_back.
`default_nettype none

module multilevel_feedback_queue_scheduler
    import mfq_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [CMD_W-1:0]     command,
    input  wire logic [SLOT_W-1:0]    slot,
    input  wire logic [DATA_W-1:0]    burst,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [SLOT_W-1:0]         job_slot,
    output logic [DATA_W-1:0]         run_units,
    output logic [DATA_W-1:0]         time_left,
    output logic [LEVEL_W-1:0]        job_level,
    output logic                      finished,
    output logic [ELAPSED_W-1:0]      elapsed,
    output logic                      all_done,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    quanta_t quanta_reg;
    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_pop;
    res_t    res;

    // quantum registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quanta_reg[0] <= QUANTUM0_RESET;
            quanta_reg[1] <= QUANTUM1_RESET;
            quanta_reg[2] <= QUANTUM2_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LEVEL0_QUANTUM: quanta_reg[0] <= cfg_data;
                CFG_LEVEL1_QUANTUM: quanta_reg[1] <= cfg_data;
                CFG_LEVEL2_QUANTUM: quanta_reg[2] <= cfg_data;
                default:            quanta_reg    <= quanta_reg;
            endcase
        end
    end

    mfq_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .slot      (slot),
        .burst     (burst),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mfq_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .quanta    (quanta_reg),
        .empty     (empty),
        .res       (res),
        .pop       (pop)
    );

    // result fields
    assign job_slot  = res.job_slot;
    assign run_units = res.run_units;
    assign time_left = res.time_left;
    assign job_level = res.job_level;
    assign finished  = res.finished;
    assign elapsed   = res.elapsed;
    assign all_done  = res.all_done;

endmodule

`default_nettype wire
